// ===== sv/mqtm_pkg.sv =====
package mqtm_pkg;

	localparam int STACK_DEPTH = 16;
	localparam int CELLS       = STACK_DEPTH - 1;
	localparam int LVL_W       = $clog2(STACK_DEPTH);
	localparam int CHAR_W      = 21;

	localparam logic [CHAR_W-1:0] CH_BACKSLASH = CHAR_W'(32'h5C);
	localparam logic [CHAR_W-1:0] CH_SQUOTE    = CHAR_W'(32'h27);
	localparam logic [CHAR_W-1:0] CH_DQUOTE    = CHAR_W'(32'h22);
	localparam logic [CHAR_W-1:0] CH_LT        = CHAR_W'(32'h3C);
	localparam logic [CHAR_W-1:0] CH_GT        = CHAR_W'(32'h3E);

	typedef enum logic [1:0] {
		CTX_PLAIN  = 2'd0,
		CTX_SINGLE = 2'd1,
		CTX_DOUBLE = 2'd2,
		CTX_TAG    = 2'd3
	} ctx_t;

	typedef enum logic [2:0] {
		MARK_NONE         = 3'd0,
		MARK_OPEN_SINGLE  = 3'd1,
		MARK_CLOSE_SINGLE = 3'd2,
		MARK_OPEN_DOUBLE  = 3'd3,
		MARK_CLOSE_DOUBLE = 3'd4,
		MARK_OPEN_TAG     = 3'd5,
		MARK_CLOSE_TAG    = 3'd6,
		MARK_ERROR        = 3'd7
	} mark_t;

	// stack move for one word; push and pop never both set
	typedef struct packed {
		logic push;
		logic pop;
		ctx_t kind;
	} stk_op_t;

	typedef struct packed {
		mark_t   mark;
		stk_op_t op;
		logic    esc_next;
		logic    ovf_set;
	} dec_t;

endpackage

// ===== sv/mqtm_cell.sv =====
module mqtm_cell (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  mqtm_pkg::stk_op_t op,
	input  mqtm_pkg::ctx_t   from_up,
	input  mqtm_pkg::ctx_t   from_down,
	output mqtm_pkg::ctx_t   q
);
	import mqtm_pkg::*;

	ctx_t entry_q;

	// push shifts entries away from the top, pop pulls them back
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q <= CTX_PLAIN;
		end else if (en) begin
			if (op.push) begin
				entry_q <= from_up;
			end else if (op.pop) begin
				entry_q <= from_down;
			end
		end
	end

	assign q = entry_q;

endmodule

// ===== sv/mqtm_decode.sv =====
module mqtm_decode (
	input  logic [mqtm_pkg::CHAR_W-1:0] ch,
	input  logic                        esc,
	input  mqtm_pkg::ctx_t              top,
	input  logic                        full,
	output mqtm_pkg::dec_t              d
);
	import mqtm_pkg::*;

	always_comb begin
		d          = '0;
		d.mark     = MARK_NONE;
		d.op.kind  = CTX_PLAIN;
		d.esc_next = 1'b0;
		if (esc) begin
			d.esc_next = 1'b0;
		end else if (ch == CH_BACKSLASH) begin
			d.esc_next = 1'b1;
		end else if (ch == CH_SQUOTE) begin
			if (top == CTX_SINGLE) begin
				d.op.pop = 1'b1;
				d.mark   = MARK_CLOSE_SINGLE;
			end else begin
				d.op.push = !full;
				d.op.kind = CTX_SINGLE;
				d.ovf_set = full;
				d.mark    = MARK_OPEN_SINGLE;
			end
		end else if (ch == CH_DQUOTE) begin
			if (top == CTX_DOUBLE) begin
				d.op.pop = 1'b1;
				d.mark   = MARK_CLOSE_DOUBLE;
			end else begin
				d.op.push = !full;
				d.op.kind = CTX_DOUBLE;
				d.ovf_set = full;
				d.mark    = MARK_OPEN_DOUBLE;
			end
		end else if (ch == CH_LT) begin
			if (top == CTX_PLAIN) begin
				d.op.push = !full;
				d.op.kind = CTX_TAG;
				d.ovf_set = full;
				d.mark    = MARK_OPEN_TAG;
			end else if (top == CTX_TAG) begin
				d.mark = MARK_ERROR;
			end
		end else if (ch == CH_GT) begin
			if (top == CTX_TAG) begin
				d.op.pop = 1'b1;
				d.mark   = MARK_CLOSE_TAG;
			end
		end
	end

endmodule

// ===== sv/markup_quote_tag_marker_core.sv =====
// channel | handshake               | word
// in      | in_valid / in_stall     | char_code[20:0]
// out     | out_valid / out_stall   | mark[2:0], overflow
//
// One word in and one word out per cycle while out is not stalled; each mark is held in the output register.
// The top of stack is cell 0 of a shift chain, read directly by the decoder.
// Reset empties the stack to plain text and clears escape and the sticky overflow flag at once.
// in_stall rises only while a finished word sits in the output register and out is stalled.
module markup_quote_tag_marker_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [mqtm_pkg::CHAR_W-1:0] char_code,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [2:0]                  mark,
	output logic                        overflow
);
	import mqtm_pkg::*;

	ctx_t             cell_q [CELLS];
	logic [LVL_W-1:0] lvl_q;
	logic             esc_q;
	logic             ovf_q;
	logic             out_valid_q;
	mark_t            mark_q;
	logic             ovf_out_q;
	dec_t             dec;
	logic             acc;
	logic             full;

	assign in_stall = out_valid_q && out_stall;
	assign acc      = in_valid && !in_stall;
	assign full     = (lvl_q == LVL_W'(STACK_DEPTH - 1));

	mqtm_decode u_decode (
		.ch   (char_code),
		.esc  (esc_q),
		.top  (cell_q[0]),
		.full (full),
		.d    (dec)
	);

	// cell i holds the entry i places below the top; plain text enters at the far end
	for (genvar i = 0; i < CELLS; i++) begin : g_cell
		ctx_t up_w;
		ctx_t down_w;
		if (i == 0) begin : g_first
			assign up_w = dec.op.kind;
		end else begin : g_mid
			assign up_w = cell_q[i-1];
		end
		if (i == CELLS - 1) begin : g_last
			assign down_w = CTX_PLAIN;
		end else begin : g_inner
			assign down_w = cell_q[i+1];
		end
		mqtm_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (acc),
			.op        (dec.op),
			.from_up   (up_w),
			.from_down (down_w),
			.q         (cell_q[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lvl_q <= '0;
			esc_q <= 1'b0;
			ovf_q <= 1'b0;
		end else if (acc) begin
			esc_q <= dec.esc_next;
			ovf_q <= ovf_q | dec.ovf_set;
			if (dec.op.push) begin
				lvl_q <= lvl_q + LVL_W'(1);
			end else if (dec.op.pop) begin
				lvl_q <= lvl_q - LVL_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!in_stall) begin
			out_valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			mark_q    <= dec.mark;
			ovf_out_q <= ovf_q | dec.ovf_set;
		end
	end

	assign out_valid = out_valid_q;
	assign mark      = mark_q;
	assign overflow  = ovf_out_q;

	// an empty stack must show plain text at the top
	a_empty_plain: assert property (@(posedge clk) disable iff (!arst_n)
		lvl_q == '0 |-> cell_q[0] == CTX_PLAIN)
		else $error("empty stack with non-plain top");

	a_ovf_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		ovf_q |=> ovf_q)
		else $error("overflow flag cleared");

	a_close_pops: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && dec.mark == MARK_CLOSE_TAG) |=> lvl_q == $past(lvl_q) - LVL_W'(1))
		else $error("tag close did not pop");

	a_push_tag_top: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && dec.op.push && dec.op.kind == CTX_TAG) |=> cell_q[0] == CTX_TAG)
		else $error("tag push lost");

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import mqtm_pkg::*;

	localparam int IDLE_LIMIT = 2000;
	localparam int RANDOM_WORDS = 1650;

	typedef struct packed {
		logic [CHAR_W-1:0] code;
		logic              typed;
		mark_t             mark;
		logic              ovf;
	} char_row_t;

	typedef struct {
		mark_t mark;
		logic  ovf;
	} mark_word_t;

	// typed rows carry their own expected mark; the rest come from the context tracker
	localparam int ROWS = 25;
	localparam char_row_t CHAR_ROWS [ROWS] = '{
		'{CHAR_W'(21'h41), 1'b1, MARK_NONE,     1'b0},
		'{CH_GT,           1'b1, MARK_NONE,     1'b0},
		'{CH_LT,           1'b1, MARK_OPEN_TAG, 1'b0},
		'{CH_LT,           1'b1, MARK_ERROR,    1'b0},
		'{CH_SQUOTE,       1'b0, MARK_NONE,     1'b0},
		'{CH_LT,           1'b0, MARK_NONE,     1'b0},
		'{CH_GT,           1'b0, MARK_NONE,     1'b0},
		'{CH_DQUOTE,       1'b0, MARK_NONE,     1'b0},
		'{CH_SQUOTE,       1'b0, MARK_NONE,     1'b0},
		'{CH_SQUOTE,       1'b0, MARK_NONE,     1'b0},
		'{CH_DQUOTE,       1'b0, MARK_NONE,     1'b0},
		'{CH_SQUOTE,       1'b0, MARK_NONE,     1'b0},
		'{CH_GT,           1'b0, MARK_NONE,     1'b0},
		'{CH_BACKSLASH,    1'b1, MARK_NONE,     1'b0},
		'{CH_BACKSLASH,    1'b1, MARK_NONE,     1'b0},
		'{CH_BACKSLASH,    1'b1, MARK_NONE,     1'b0},
		'{CH_DQUOTE,       1'b1, MARK_NONE,     1'b0},
		'{CH_BACKSLASH,    1'b1, MARK_NONE,     1'b0},
		'{CH_LT,           1'b1, MARK_NONE,     1'b0},
		'{CHAR_W'(21'h1FFFFF), 1'b1, MARK_NONE, 1'b0},
		'{CHAR_W'(21'h000000), 1'b1, MARK_NONE, 1'b0},
		'{CHAR_W'(21'h10FFFF), 1'b1, MARK_NONE, 1'b0},
		'{CH_DQUOTE,       1'b0, MARK_NONE,     1'b0},
		'{CH_DQUOTE,       1'b0, MARK_NONE,     1'b0},
		'{CHAR_W'(21'h100027), 1'b1, MARK_NONE, 1'b0}
	};

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_stall;
	logic [CHAR_W-1:0] char_code;
	logic              out_valid;
	logic              out_stall;
	logic [2:0]        mark;
	logic              overflow;

	// context tracker state
	ctx_t ctx_stk [STACK_DEPTH];
	int   ctx_lvl;
	bit   esc_armed;
	bit   ovf_flag;

	mark_word_t mark_q [$];
	mark_word_t head_word;
	int         mismatches;
	int         idle_cycles;
	int         burst_left;
	int         gap;

	markup_quote_tag_marker_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.char_code (char_code),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.mark      (mark),
		.overflow  (overflow)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	task automatic ctx_push(input ctx_t kind);
		if (ctx_lvl + 1 < STACK_DEPTH) begin
			ctx_lvl++;
			ctx_stk[ctx_lvl] = kind;
		end else begin
			ovf_flag = 1'b1;
		end
	endtask

	task automatic ctx_pop();
		if (ctx_lvl > 0)
			ctx_lvl--;
	endtask

	task automatic mark_char(input logic [CHAR_W-1:0] c, output mark_t m, output logic o);
		ctx_t top;
		ctx_t kind;
		m = MARK_NONE;
		top = ctx_stk[ctx_lvl];
		if (esc_armed) begin
			esc_armed = 1'b0;
		end else if (c == CH_BACKSLASH) begin
			esc_armed = 1'b1;
		end else if (c == CH_SQUOTE || c == CH_DQUOTE) begin
			kind = (c == CH_SQUOTE) ? CTX_SINGLE : CTX_DOUBLE;
			if (top == kind) begin
				ctx_pop();
				m = (kind == CTX_SINGLE) ? MARK_CLOSE_SINGLE : MARK_CLOSE_DOUBLE;
			end else begin
				ctx_push(kind);
				m = (kind == CTX_SINGLE) ? MARK_OPEN_SINGLE : MARK_OPEN_DOUBLE;
			end
		end else if (c == CH_LT) begin
			if (top == CTX_PLAIN) begin
				ctx_push(CTX_TAG);
				m = MARK_OPEN_TAG;
			end else if (top == CTX_TAG) begin
				m = MARK_ERROR;
			end
		end else if (c == CH_GT) begin
			if (top == CTX_TAG) begin
				ctx_pop();
				m = MARK_CLOSE_TAG;
			end
		end
		o = ovf_flag;
	endtask

	// capped: on a full stack close the top instead, so overflow stays clear until the end
	function automatic logic [CHAR_W-1:0] pick_char(input bit capped);
		int r;
		r = $urandom_range(0, 99);
		if (capped && !esc_armed && ctx_lvl == STACK_DEPTH - 1) begin
			case (ctx_stk[ctx_lvl])
				CTX_SINGLE: return CH_SQUOTE;
				CTX_DOUBLE: return CH_DQUOTE;
				default: return CH_GT;
			endcase
		end
		if (r < 10)
			return CH_BACKSLASH;
		if (r < 25)
			return CH_SQUOTE;
		if (r < 40)
			return CH_DQUOTE;
		if (r < 52)
			return CH_LT;
		if (r < 64)
			return CH_GT;
		if (r < 82)
			return CHAR_W'($urandom_range(32'h20, 32'h7E));
		if (r < 92)
			return CHAR_W'($urandom_range(0, 32'h10FFFF));
		return CHAR_W'($urandom);
	endfunction

	task automatic send_char(input logic [CHAR_W-1:0] c, input logic typed,
			input mark_t t_mark, input logic t_ovf);
		mark_t      m;
		logic       o;
		mark_word_t w;
		if (burst_left == 0) begin
			case ($urandom_range(0, 7))
				0: begin
					burst_left = 200;
					gap = 0;
				end
				1: begin
					burst_left = $urandom_range(1, 4);
					gap = $urandom_range(5, 20);
				end
				default: begin
					burst_left = $urandom_range(1, 40);
					gap = $urandom_range(0, 4);
				end
			endcase
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		char_code <= c;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		mark_char(c, m, o);
		if (typed) begin
			w.mark = t_mark;
			w.ovf = t_ovf;
		end else begin
			w.mark = m;
			w.ovf = o;
		end
		mark_q = {mark_q, w};
	endtask

	initial begin
		in_valid <= 1'b0;
		char_code <= '0;
		arst_n <= 1'b0;
		foreach (ctx_stk[i])
			ctx_stk[i] = CTX_PLAIN;
		ctx_lvl = 0;
		esc_armed = 1'b0;
		ovf_flag = 1'b0;
		burst_left = 0;
		gap = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < ROWS; i++)
			send_char(CHAR_ROWS[i].code, CHAR_ROWS[i].typed, CHAR_ROWS[i].mark,
				CHAR_ROWS[i].ovf);

		for (int k = 0; k < RANDOM_WORDS; k++)
			send_char(pick_char(1'b1), 1'b0, MARK_NONE, 1'b0);

		// nest quotes past the top of the stack to raise the sticky flag
		for (int k = 0; k < 18; k++)
			send_char(ctx_stk[ctx_lvl] == CTX_SINGLE ? CH_DQUOTE : CH_SQUOTE, 1'b0,
				MARK_NONE, 1'b0);

		for (int k = 0; k < 60; k++)
			send_char(pick_char(1'b0), 1'b0, MARK_NONE, 1'b0);

		// finish on an unescaped backslash, left pending
		if (esc_armed)
			send_char(CHAR_W'(21'h41), 1'b0, MARK_NONE, 1'b0);
		send_char(CH_BACKSLASH, 1'b0, MARK_NONE, 1'b0);
		in_valid <= 1'b0;

		while (mark_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		if (mismatches == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// receiver: stall pattern drawn at random from four modes, plus one long hold-off
	initial begin
		int cyc;
		int mode;
		cyc = 0;
		mode = 0;
		out_stall <= 1'b0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			cyc++;
			if (cyc == 700) begin
				out_stall <= 1'b1;
				repeat (250) @(posedge clk);
				cyc++;
			end
			if (cyc % 64 == 0)
				mode = $urandom_range(0, 3);
			case (mode)
				0: out_stall <= 1'b0;
				1: out_stall <= ($urandom_range(0, 3) == 0);
				2: out_stall <= ($urandom_range(0, 3) != 0);
				default: out_stall <= (cyc % 3 == 0);
			endcase
		end
	end

	initial mismatches = 0;

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (mark_q.size() == 0) begin
				$display("%0t: word with nothing expected, mark %0d overflow %0b",
					$time, mark, overflow);
				mismatches++;
			end else begin
				head_word = mark_q.pop_front();
				if (mark !== head_word.mark) begin
					$display("%0t: mark expected %0d got %0d", $time, head_word.mark, mark);
					mismatches++;
				end
				if (overflow !== head_word.ovf) begin
					$display("%0t: overflow expected %0b got %0b", $time, head_word.ovf,
						overflow);
					mismatches++;
				end
			end
		end
	end

	initial idle_cycles = 0;

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("%0t: timeout, %0d words outstanding", $time, mark_q.size());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

endmodule

// ===== filelist.f =====
sv/mqtm_pkg.sv
sv/mqtm_cell.sv
sv/mqtm_decode.sv
sv/markup_quote_tag_marker_core.sv
tb/tb_top.sv
